[hw/rtl/assert_macros.svh]
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every edge.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

[hw/rtl/spe_pkg.sv]
`default_nettype none
package spe_pkg;

  localparam int unsigned RES_DEPTH = 63;
  localparam int unsigned RES_AW    = 6;
  localparam int unsigned RES_CW    = 7;

  typedef enum logic [3:0] {
    OP_CLEAR  = 4'd0,
    OP_LOAD_A = 4'd1,
    OP_LOAD_B = 4'd2,
    OP_A_SUB  = 4'd3,
    OP_B_SUB  = 4'd4,
    OP_MUL    = 4'd5,
    OP_EVAL_A = 4'd6,
    OP_EVAL_B = 4'd7,
    OP_EVAL_R = 4'd8
  } op_e;

  typedef struct packed {
    logic        [3:0]  operation;
    logic signed [15:0] term_coefficient;
    logic        [4:0]  term_exponent;
    logic signed [15:0] x_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_coefficient;
    logic        [5:0]  out_exponent;
    logic signed [31:0] eval_value;
    logic               empty_res;
    logic               overflow_error;
    logic               last;
  } rsp_t;

  // stored input term
  typedef struct packed {
    logic [15:0] coef;
    logic [4:0]  expo;
  } term_t;

  // stored result term
  typedef struct packed {
    logic [31:0] coef;
    logic [5:0]  expo;
  } rterm_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/spe_ifs.sv]
`default_nettype none
interface spe_req_if;
  logic          valid;
  logic          ready;
  spe_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spe_rsp_if;
  logic          valid;
  logic          ready;
  spe_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sparse_polynomial_engine_top.sv]
// Sparse polynomial engine: holds polynomials A and B (up to MAX_TERMS terms each; the user
// must load them in descending exponent order, which the block does not enforce) and on
// request returns A-B, B-A or A*B term by term, highest exponent first, with last set on
// the final term, or evaluates A, B or the last result at x. One request is worked at a
// time, around synchronously read memories. Clear, load and unknown requests are acked
// directly. A merge writes each result term in turn, then emits them. A product clears the
// 2*MAX_EXPONENT+1 accumulators, adds the product of each pair of A and B terms into the
// accumulator of their exponent sum, scans the accumulators from the highest exponent
// down, storing the non-zero sums, and emits them. An evaluation builds the power of x for
// each term by one multiply per cycle, scales it by the coefficient and adds it to the sum.
// A load past capacity or with an exponent above MAX_EXPONENT is dropped and its ack
// carries overflow_error. A finished result waits in an output register until taken.
`default_nettype none
`include "assert_macros.svh"
module sparse_polynomial_engine_top #(
  parameter int unsigned MAX_TERMS    = 16,
  parameter int unsigned MAX_EXPONENT = 31
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  spe_req_if.sink     req_i,
  spe_rsp_if.source   rsp_o
);

  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned ACC_DEPTH = 2 * MAX_EXPONENT + 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACK, ST_FIN,
    ST_MG_RD, ST_MG_DO,
    ST_PR_CLR, ST_PR_A, ST_PR_LA, ST_PR_B, ST_PR_RDACC, ST_PR_WR,
    ST_SC_RD, ST_SC_DO,
    ST_EM_RD, ST_EM_OUT,
    ST_EV_RD, ST_EV_LD, ST_EV_POW, ST_EV_MUL, ST_EV_ACC
  } state_e;

  // memories
  spe_pkg::term_t  a_mem   [MAX_TERMS];
  spe_pkg::term_t  b_mem   [MAX_TERMS];
  spe_pkg::rterm_t res_mem [spe_pkg::RES_DEPTH];
  logic [31:0]     acc_mem [ACC_DEPTH];

  spe_pkg::term_t  a_rd_q, b_rd_q;
  spe_pkg::rterm_t res_rd_q;
  logic [31:0]     acc_rd_q;

  state_e             state_q;
  logic [3:0]         op_q;
  logic [15:0]        x_q;
  logic [CNT_W-1:0]   a_cnt_q, b_cnt_q;
  logic [spe_pkg::RES_CW-1:0] res_cnt_q, k_q;
  logic [CNT_W-1:0]   pi_q, qi_q;
  logic [5:0]         acc_idx_q;
  logic [15:0]        ca_q;
  logic [4:0]         ea_q;
  logic [31:0]        prod_q, sum_q, pw_q, ecoef_q;
  logic [5:0]         ecnt_q;
  logic               ovf_q;
  logic               rsp_valid_q;
  spe_pkg::rsp_t      rsp_q;

  // combinational memory controls
  logic                      a_we, b_we, res_we, acc_we;
  logic [IDX_W-1:0]          a_raddr, b_raddr;
  logic [5:0]                acc_raddr, acc_waddr;
  logic [31:0]               acc_wdata;
  spe_pkg::rterm_t           res_wdata;

  logic       req_fire, out_free, swap, load_ok, take_p, take_q;
  logic [CNT_W-1:0] pn, qn;
  logic       p_ok, q_ok;
  spe_pkg::term_t p_t, q_t;
  spe_pkg::term_t ev_t;
  logic [spe_pkg::RES_CW-1:0] ev_n;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // merge operands: P minus Q, B-A swaps the roles
  assign swap = (op_q == spe_pkg::OP_B_SUB);
  assign pn   = swap ? b_cnt_q : a_cnt_q;
  assign qn   = swap ? a_cnt_q : b_cnt_q;
  assign p_ok = pi_q < pn;
  assign q_ok = qi_q < qn;
  assign p_t  = swap ? b_rd_q : a_rd_q;
  assign q_t  = swap ? a_rd_q : b_rd_q;
  assign take_p = !q_ok || (p_ok && (p_t.expo > q_t.expo));
  assign take_q = !take_p && (!p_ok || (p_t.expo < q_t.expo));

  assign load_ok = ({1'b0, req_i.data.term_exponent} <= 6'(MAX_EXPONENT)) &&
                   (((req_i.data.operation == spe_pkg::OP_LOAD_A) ?
                     a_cnt_q : b_cnt_q) != CNT_W'(MAX_TERMS));

  always_comb begin
    unique case (op_q)
      spe_pkg::OP_EVAL_A: begin
        ev_t = a_rd_q;
        ev_n = spe_pkg::RES_CW'(a_cnt_q);
      end
      spe_pkg::OP_EVAL_B: begin
        ev_t = b_rd_q;
        ev_n = spe_pkg::RES_CW'(b_cnt_q);
      end
      default: begin
        ev_t = '0;
        ev_n = res_cnt_q;
      end
    endcase
  end

  always_comb begin
    a_we      = 1'b0;
    b_we      = 1'b0;
    res_we    = 1'b0;
    acc_we    = 1'b0;
    a_raddr   = k_q[IDX_W-1:0];
    b_raddr   = k_q[IDX_W-1:0];
    acc_raddr = acc_idx_q;
    acc_waddr = acc_idx_q;
    acc_wdata = '0;
    res_wdata = '0;
    if (req_fire && load_ok) begin
      a_we = (req_i.data.operation == spe_pkg::OP_LOAD_A);
      b_we = (req_i.data.operation == spe_pkg::OP_LOAD_B);
    end
    unique case (state_q)
      ST_MG_RD, ST_MG_DO: begin
        a_raddr = swap ? qi_q[IDX_W-1:0] : pi_q[IDX_W-1:0];
        b_raddr = swap ? pi_q[IDX_W-1:0] : qi_q[IDX_W-1:0];
      end
      ST_PR_A, ST_PR_LA, ST_PR_B, ST_PR_RDACC, ST_PR_WR: begin
        a_raddr = pi_q[IDX_W-1:0];
        b_raddr = qi_q[IDX_W-1:0];
      end
      default: ;
    endcase
    unique case (state_q)
      ST_MG_DO: begin
        res_we = 1'b1;
        if (take_p) begin
          res_wdata = '{coef: spe_pkg::sext16(p_t.coef), expo: {1'b0, p_t.expo}};
        end else if (take_q) begin
          res_wdata = '{coef: 32'd0 - spe_pkg::sext16(q_t.coef), expo: {1'b0, q_t.expo}};
        end else begin
          res_wdata = '{coef: spe_pkg::sext16(p_t.coef) - spe_pkg::sext16(q_t.coef),
                        expo: {1'b0, p_t.expo}};
        end
      end
      ST_PR_CLR: acc_we = 1'b1;
      ST_PR_RDACC: acc_raddr = {1'b0, ea_q} + {1'b0, b_rd_q.expo};
      ST_PR_WR: begin
        acc_we    = 1'b1;
        acc_wdata = acc_rd_q + prod_q;
      end
      ST_SC_DO: begin
        res_we    = (acc_rd_q != '0);
        res_wdata = '{coef: acc_rd_q, expo: acc_idx_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_cnt_q[IDX_W-1:0]] <= '{coef: req_i.data.term_coefficient,
                                     expo: req_i.data.term_exponent};
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_cnt_q[IDX_W-1:0]] <= '{coef: req_i.data.term_coefficient,
                                     expo: req_i.data.term_exponent};
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[k_q[spe_pkg::RES_AW-1:0]] <= res_wdata;
    end
    res_rd_q <= res_mem[k_q[spe_pkg::RES_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd_q <= acc_mem[acc_raddr];
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q  <= req_i.data.operation;
        x_q   <= req_i.data.x_value;
        sum_q <= '0;
      end
      ST_PR_LA: begin
        ca_q <= a_rd_q.coef;
        ea_q <= a_rd_q.expo;
      end
      ST_PR_RDACC: prod_q <= spe_pkg::sext16(ca_q) * spe_pkg::sext16(b_rd_q.coef);
      ST_EV_LD: begin
        ecoef_q <= (op_q == spe_pkg::OP_EVAL_R) ? res_rd_q.coef : spe_pkg::sext16(ev_t.coef);
        ecnt_q  <= (op_q == spe_pkg::OP_EVAL_R) ? res_rd_q.expo : {1'b0, ev_t.expo};
        pw_q    <= 32'd1;
      end
      ST_EV_POW: begin
        if (ecnt_q != '0) begin
          pw_q   <= pw_q * spe_pkg::sext16(x_q);
          ecnt_q <= ecnt_q - 6'd1;
        end
      end
      ST_EV_MUL: prod_q <= ecoef_q * pw_q;
      ST_EV_ACC: sum_q  <= sum_q + prod_q;
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      res_cnt_q   <= '0;
      k_q         <= '0;
      pi_q        <= '0;
      qi_q        <= '0;
      acc_idx_q   <= '0;
      ovf_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      // output states load a new item whenever the register is empty or taken
      if (rsp_o.ready && state_q != ST_ACK && state_q != ST_EM_OUT) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            ovf_q <= ((req_i.data.operation == spe_pkg::OP_LOAD_A) ||
                      (req_i.data.operation == spe_pkg::OP_LOAD_B)) && !load_ok;
            pi_q  <= '0;
            qi_q  <= '0;
            k_q   <= '0;
            acc_idx_q <= '0;
            priority case (req_i.data.operation)
              spe_pkg::OP_CLEAR: begin
                a_cnt_q   <= '0;
                b_cnt_q   <= '0;
                res_cnt_q <= '0;
                state_q   <= ST_ACK;
              end
              spe_pkg::OP_LOAD_A, spe_pkg::OP_LOAD_B: begin
                if (load_ok && req_i.data.operation == spe_pkg::OP_LOAD_A) begin
                  a_cnt_q <= a_cnt_q + 1'b1;
                end
                if (load_ok && req_i.data.operation == spe_pkg::OP_LOAD_B) begin
                  b_cnt_q <= b_cnt_q + 1'b1;
                end
                state_q <= ST_ACK;
              end
              spe_pkg::OP_A_SUB, spe_pkg::OP_B_SUB: state_q <= ST_MG_RD;
              spe_pkg::OP_MUL: state_q <= ST_PR_CLR;
              spe_pkg::OP_EVAL_A, spe_pkg::OP_EVAL_B, spe_pkg::OP_EVAL_R:
                state_q <= ST_EV_RD;
              default: state_q <= ST_ACK;
            endcase
          end
        end
        ST_ACK: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            rsp_q <= '{out_coefficient: '0, out_exponent: '0, eval_value: sum_q,
                       empty_res: 1'b1, overflow_error: ovf_q, last: 1'b1};
            state_q <= ST_IDLE;
          end
        end
        ST_FIN: begin
          res_cnt_q <= k_q;
          k_q       <= '0;
          state_q   <= (k_q == '0) ? ST_ACK : ST_EM_RD;
        end
        // a merge stops once the result store is full
        ST_MG_RD: state_q <= ((p_ok || q_ok) &&
                              (k_q != spe_pkg::RES_CW'(spe_pkg::RES_DEPTH))) ?
                             ST_MG_DO : ST_FIN;
        ST_MG_DO: begin
          if (take_p || !take_q) pi_q <= pi_q + 1'b1;
          if (!take_p) qi_q <= qi_q + 1'b1;
          k_q     <= k_q + 1'b1;
          state_q <= ST_MG_RD;
        end
        ST_PR_CLR: begin
          if (acc_idx_q == 6'(ACC_DEPTH - 1)) begin
            state_q <= ST_PR_A;
          end else begin
            acc_idx_q <= acc_idx_q + 6'd1;
          end
        end
        ST_PR_A: begin
          if (pi_q == a_cnt_q) begin
            acc_idx_q <= 6'(ACC_DEPTH - 1);
            state_q   <= ST_SC_RD;
          end else begin
            state_q <= ST_PR_LA;
          end
        end
        ST_PR_LA: begin
          qi_q    <= '0;
          state_q <= ST_PR_B;
        end
        ST_PR_B: begin
          if (qi_q == b_cnt_q) begin
            pi_q    <= pi_q + 1'b1;
            state_q <= ST_PR_A;
          end else begin
            state_q <= ST_PR_RDACC;
          end
        end
        ST_PR_RDACC: begin
          acc_idx_q <= acc_raddr;
          state_q   <= ST_PR_WR;
        end
        ST_PR_WR: begin
          qi_q    <= qi_q + 1'b1;
          state_q <= ST_PR_B;
        end
        ST_SC_RD: state_q <= ST_SC_DO;
        ST_SC_DO: begin
          if (res_we) k_q <= k_q + 1'b1;
          if (acc_idx_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            acc_idx_q <= acc_idx_q - 6'd1;
            state_q   <= ST_SC_RD;
          end
        end
        ST_EM_RD: state_q <= ST_EM_OUT;
        ST_EM_OUT: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            rsp_q <= '{out_coefficient: res_rd_q.coef, out_exponent: res_rd_q.expo,
                       eval_value: '0, empty_res: 1'b0, overflow_error: 1'b0,
                       last: (k_q + 1'b1 == res_cnt_q)};
            k_q     <= k_q + 1'b1;
            state_q <= (k_q + 1'b1 == res_cnt_q) ? ST_IDLE : ST_EM_RD;
          end
        end
        ST_EV_RD:  state_q <= (k_q == ev_n) ? ST_ACK : ST_EV_LD;
        ST_EV_LD:  state_q <= ST_EV_POW;
        ST_EV_POW: if (ecnt_q == '0) state_q <= ST_EV_MUL;
        ST_EV_MUL: state_q <= ST_EV_ACC;
        ST_EV_ACC: begin
          k_q     <= k_q + 1'b1;
          state_q <= ST_EV_RD;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_cnt_cap_a, a_cnt_q <= CNT_W'(MAX_TERMS), "A count beyond capacity")
  `ASSERT_IMP(acc_idx_rng_a, state_q == ST_PR_WR, acc_idx_q < 6'(ACC_DEPTH),
              "accumulator index out of range")
  `ASSERT_IMP(term_not_last_a, rsp_valid_q && !rsp_q.last, !rsp_q.empty_res,
              "non-final item carries no term")

endmodule
`default_nettype wire

[verif/spe_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module spe_checker (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            req_valid_i,
  input  wire            req_ready_i,
  input  spe_pkg::req_t  req_data_i,
  input  wire            rsp_valid_i,
  input  wire            rsp_ready_i,
  input  spe_pkg::rsp_t  rsp_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  localparam int unsigned NTERMS = 16;
  localparam int unsigned MAXEXP = 31;
  localparam int unsigned ACCN   = 2 * MAXEXP + 1;

  logic [31:0] a_coef [NTERMS];
  logic [4:0]  a_expo [NTERMS];
  int unsigned a_num;
  logic [31:0] b_coef [NTERMS];
  logic [4:0]  b_expo [NTERMS];
  int unsigned b_num;
  logic [31:0] r_coef [spe_pkg::RES_DEPTH];
  logic [5:0]  r_expo [spe_pkg::RES_DEPTH];
  int unsigned r_num;

  spe_pkg::rsp_t expected_rsps[$];
  int unsigned   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsps.size();

  function automatic spe_pkg::rsp_t ack(logic [31:0] ev, logic ovf);
    spe_pkg::rsp_t r;
    r = '0;
    r.eval_value     = ev;
    r.empty_res      = 1'b1;
    r.overflow_error = ovf;
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] poly_value(logic [31:0] c[$], logic [5:0] e[$],
                                             logic [31:0] x);
    logic [31:0] sum, p;
    sum = '0;
    foreach (c[i]) begin
      p = 32'd1;
      for (int t = 0; t < e[i]; t++) p = p * x;
      sum = sum + c[i] * p;
    end
    return sum;
  endfunction

  // Descending merge of P minus Q into the result store.
  task automatic merge_diff(logic [31:0] pc[$], logic [4:0] pe[$],
                            logic [31:0] qc[$], logic [4:0] qe[$]);
    int unsigned i, j, k;
    i = 0; j = 0; k = 0;
    while (k < spe_pkg::RES_DEPTH && (i < pc.size() || j < qc.size())) begin
      if (j >= qc.size() || (i < pc.size() && pe[i] > qe[j])) begin
        r_coef[k] = pc[i]; r_expo[k] = pe[i]; i++;
      end else if (i >= pc.size() || pe[i] < qe[j]) begin
        r_coef[k] = -qc[j]; r_expo[k] = qe[j]; j++;
      end else begin
        r_coef[k] = pc[i] - qc[j]; r_expo[k] = pe[i]; i++; j++;
      end
      k++;
    end
    r_num = k;
  endtask

  task automatic product_ab();
    logic [31:0] acc [ACCN];
    int unsigned k;
    k = 0;
    foreach (acc[x]) acc[x] = '0;
    for (int i = 0; i < a_num; i++)
      for (int j = 0; j < b_num; j++)
        acc[int'(a_expo[i]) + int'(b_expo[j])] += a_coef[i] * b_coef[j];
    for (int x = ACCN - 1; x >= 0; x--)
      if (acc[x] != 0 && k < spe_pkg::RES_DEPTH) begin
        r_coef[k] = acc[x]; r_expo[k] = x[5:0]; k++;
      end
    r_num = k;
  endtask

  task automatic predict(spe_pkg::req_t rq);
    logic [31:0] ac[$], bc[$], rc[$];
    logic [4:0]  ae[$], be[$];
    logic [5:0]  ae6[$], be6[$], re[$];
    logic [31:0] xv;
    spe_pkg::rsp_t r;
    xv = spe_pkg::sext16(rq.x_value);
    for (int i = 0; i < a_num; i++) begin
      ac.push_back(a_coef[i]); ae.push_back(a_expo[i]); ae6.push_back({1'b0, a_expo[i]});
    end
    for (int i = 0; i < b_num; i++) begin
      bc.push_back(b_coef[i]); be.push_back(b_expo[i]); be6.push_back({1'b0, b_expo[i]});
    end
    for (int i = 0; i < r_num; i++) begin
      rc.push_back(r_coef[i]); re.push_back(r_expo[i]);
    end
    case (rq.operation)
      spe_pkg::OP_CLEAR: begin
        a_num = 0; b_num = 0; r_num = 0;
        expected_rsps.push_back(ack('0, 1'b0));
      end
      spe_pkg::OP_LOAD_A: begin
        if (a_num >= NTERMS) expected_rsps.push_back(ack('0, 1'b1));
        else begin
          a_coef[a_num] = spe_pkg::sext16(rq.term_coefficient);
          a_expo[a_num] = rq.term_exponent;
          a_num++;
          expected_rsps.push_back(ack('0, 1'b0));
        end
      end
      spe_pkg::OP_LOAD_B: begin
        if (b_num >= NTERMS) expected_rsps.push_back(ack('0, 1'b1));
        else begin
          b_coef[b_num] = spe_pkg::sext16(rq.term_coefficient);
          b_expo[b_num] = rq.term_exponent;
          b_num++;
          expected_rsps.push_back(ack('0, 1'b0));
        end
      end
      spe_pkg::OP_A_SUB, spe_pkg::OP_B_SUB, spe_pkg::OP_MUL: begin
        if (rq.operation == spe_pkg::OP_A_SUB) merge_diff(ac, ae, bc, be);
        else if (rq.operation == spe_pkg::OP_B_SUB) merge_diff(bc, be, ac, ae);
        else product_ab();
        if (r_num == 0) expected_rsps.push_back(ack('0, 1'b0));
        for (int k = 0; k < r_num; k++) begin
          r = '0;
          r.out_coefficient = r_coef[k];
          r.out_exponent    = r_expo[k];
          r.last            = (k + 1 == r_num);
          expected_rsps.push_back(r);
        end
      end
      spe_pkg::OP_EVAL_A: expected_rsps.push_back(ack(poly_value(ac, ae6, xv), 1'b0));
      spe_pkg::OP_EVAL_B: expected_rsps.push_back(ack(poly_value(bc, be6, xv), 1'b0));
      spe_pkg::OP_EVAL_R: expected_rsps.push_back(ack(poly_value(rc, re, xv), 1'b0));
      default:   expected_rsps.push_back(ack('0, 1'b0));
    endcase
  endtask

  task automatic report(string what, spe_pkg::rsp_t got, spe_pkg::rsp_t want);
    fails++;
    $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spe_pkg::rsp_t want;
    if (!rst_ni) begin
      a_num = 0; b_num = 0; r_num = 0; fails = 0;
      expected_rsps.delete();
    end else begin
      // responses first: a request accepted this edge cannot yet be answered
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsps.size() == 0) report("unexpected response", rsp_data_i, '0);
        else begin
          want = expected_rsps.pop_front();
          if (rsp_data_i.out_coefficient != want.out_coefficient)
            report("out_coefficient", rsp_data_i, want);
          else if (rsp_data_i.out_exponent != want.out_exponent)
            report("out_exponent", rsp_data_i, want);
          else if (rsp_data_i.eval_value != want.eval_value)
            report("eval_value", rsp_data_i, want);
          else if (rsp_data_i.empty_res != want.empty_res)
            report("empty_res", rsp_data_i, want);
          else if (rsp_data_i.overflow_error != want.overflow_error)
            report("overflow_error", rsp_data_i, want);
          else if (rsp_data_i.last != want.last)
            report("last", rsp_data_i, want);
        end
      end
      if (req_valid_i && req_ready_i) predict(req_data_i);
    end
  end
endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
// Stimulus for the sparse polynomial engine. Loads A and B, mostly with descending
// terms, runs merges, products and evaluations; checking lives in spe_checker.
module tb_top;

  logic clk_i;
  logic rst_ni;

  spe_req_if req_if ();
  spe_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned pending;
  bit          calm;   // disables random idling on both sides

  sparse_polynomial_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  spe_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_data_i   (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_data_i   (rsp_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // response side: ready drops at random with 11 percent probability, unless calm
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // hard limit on simulation time; reaching it reports mismatches
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // Send one request; random idle cycles beforehand unless calm, held until accepted.
  task automatic send(spe_pkg::op_e op, logic [15:0] c, logic [4:0] e, logic [15:0] x);
    spe_pkg::req_t rq;
    while (!calm && $urandom_range(99) < 11) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rq.operation        = op;
    rq.term_coefficient = c;
    rq.term_exponent    = e;
    rq.x_value          = x;
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_op(spe_pkg::op_e op);
    send(op, 16'($urandom), 5'($urandom), 16'($urandom));
  endtask

  // Load a random descending polynomial of n terms into A or B.
  task automatic load_poly(spe_pkg::op_e op, int n);
    int e;
    e = $urandom_range(31, n - 1);
    for (int i = 0; i < n; i++) begin
      send(op, 16'($urandom), e[4:0], 16'($urandom));
      if (i < n - 1) e = $urandom_range(e - 1, n - 2 - i);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty results, extremes, equal exponents giving zero terms
    send(spe_pkg::OP_A_SUB, 0, 0, 0);
    send(spe_pkg::OP_MUL, 0, 0, 0);
    send(spe_pkg::OP_EVAL_R, 0, 0, 16'h7fff);
    send(spe_pkg::OP_LOAD_A, 16'h7fff, 5'd31, 0);
    send(spe_pkg::OP_LOAD_A, 16'h8000, 5'd5, 0);
    send(spe_pkg::OP_LOAD_A, 16'hffff, 5'd0, 0);
    send(spe_pkg::OP_LOAD_B, 16'h7fff, 5'd31, 0);
    send(spe_pkg::OP_LOAD_B, 16'h0001, 5'd3, 0);
    send(spe_pkg::OP_A_SUB, 0, 0, 0);
    send(spe_pkg::OP_B_SUB, 0, 0, 0);
    send(spe_pkg::OP_MUL, 0, 0, 0);
    send(spe_pkg::OP_EVAL_A, 0, 0, 16'h8000);
    send(spe_pkg::OP_EVAL_B, 0, 0, 16'hffff);
    send(spe_pkg::OP_EVAL_R, 0, 0, 16'h0002);
    send(spe_pkg::op_e'(4'd9), 16'hffff, 5'd31, 16'hffff);
    send(spe_pkg::op_e'(4'd15), 0, 0, 0);
    // non-descending load, then fill A past capacity
    send(spe_pkg::OP_LOAD_B, 16'h0010, 5'd20, 0);
    for (int i = 0; i < 14; i++) begin
      send(spe_pkg::OP_LOAD_A, 16'($urandom), 5'($urandom), 0);
    end
    send(spe_pkg::OP_A_SUB, 0, 0, 0);
    send(spe_pkg::OP_MUL, 0, 0, 0);
    send(spe_pkg::OP_CLEAR, 0, 0, 0);
    drain();

    // random: mostly well-formed load/compute sequences; one calm stretch
    for (int round = 0; round < 7; round++) begin
      calm = (round == 4 || round == 5);
      send(spe_pkg::OP_CLEAR, 0, 0, 0);
      load_poly(spe_pkg::OP_LOAD_A, $urandom_range(1, (round % 3 == 0) ? 16 : 5));
      load_poly(spe_pkg::OP_LOAD_B, $urandom_range(1, (round % 4 == 0) ? 16 : 5));
      for (int i = 0; i < 4; i++) begin
        pick = $urandom_range(9);
        if (pick < 2) send_op(spe_pkg::OP_A_SUB);
        else if (pick < 4) send_op(spe_pkg::OP_B_SUB);
        else if (pick < 6) send_op(spe_pkg::OP_MUL);
        else if (pick == 6) send_op(spe_pkg::OP_EVAL_A);
        else if (pick == 7) send_op(spe_pkg::OP_EVAL_B);
        else if (pick == 8) send_op(spe_pkg::OP_EVAL_R);
        else send_op(spe_pkg::op_e'(4'($urandom)));
      end
      if (round == 3) drain();
    end
    calm = 1'b0;

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
